/* rtl/ssl_pkg.sv */
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared widths, mode codes and pipeline side-band types for the slope limiter.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int QUOT_W  = DATA_W + 2;
  localparam int NUM_W   = 3 * DATA_W;
  localparam int DEN_W   = 2 * DATA_W + 2;
  localparam int REM_W   = DEN_W + 1;
  localparam int MAG_W   = QUOT_W + 2;
  localparam int EPS_W   = DATA_W - 1;
  localparam int IDX_W   = 8;
  localparam int LANES   = 2;

  localparam logic [IDX_W-1:0] REG_MODE = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EPS  = IDX_W'(1);

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_FIRST,
    MODE_MINMOD,
    MODE_VANLEER,
    MODE_BLEND,
    MODE_ALBADA,
    MODE_BARTH,
    MODE_VENKAT
  } mode_t;

  // per-item information that rides alongside the divider lanes
  typedef struct packed {
    mode_t             mode;
    logic              xneg;
    logic              yneg;
    logic              xzero;
    logic              yzero;
    logic              dzero;
    logic              vneg;
    logic [DATA_W-1:0] mn;
  } side_t;

endpackage

/* rtl/ssl_in_if.sv */
// ----------------------------------------------------------------------------
// ssl_in_if
// Request channel carrying one pair of one-sided differences.
// ----------------------------------------------------------------------------
interface ssl_in_if import ssl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] left_diff;
  logic [DATA_W-1:0] right_diff;

  modport source (output valid, left_diff, right_diff, input ready);
  modport sink (input valid, left_diff, right_diff, output ready);
endinterface

/* rtl/ssl_out_if.sv */
// ----------------------------------------------------------------------------
// ssl_out_if
// Result channel carrying the limiter value and its saturation flag.
// ----------------------------------------------------------------------------
interface ssl_out_if import ssl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] limited_value;
  logic              saturated;

  modport source (output valid, limited_value, saturated, input ready);
  modport sink (input valid, limited_value, saturated, output ready);
endinterface

/* rtl/ssl_cfg_if.sv */
// ----------------------------------------------------------------------------
// ssl_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface ssl_cfg_if import ssl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ssl_front.sv */
// ----------------------------------------------------------------------------
// ssl_front
// Operand stages: magnitudes, products, sums and per-mode dividend/divisor.
// ----------------------------------------------------------------------------
module ssl_front import ssl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [DATA_W-1:0] left_diff,
  input  logic [DATA_W-1:0] right_diff,
  input  mode_t             mode,
  input  logic [EPS_W-1:0]  eps,
  output logic              o_valid,
  output side_t             o_side,
  output logic [NUM_W-1:0]  o_num [LANES],
  output logic [DEN_W-1:0]  o_den [LANES]
);

  // stage 1
  logic              v1_r;
  logic [DATA_W-1:0] x1_r, y1_r;
  mode_t             m1_r;
  logic [EPS_W-1:0]  e1_r;
  // stage 2
  logic              v2_r, xn2_r, yn2_r;
  logic [DATA_W-1:0] xa2_r, ya2_r, mn2_r;
  logic [DATA_W:0]   sum2_r;
  mode_t             m2_r;
  logic [EPS_W-1:0]  e2_r;
  // stage 3
  logic              v3_r, xn3_r, yn3_r;
  logic [DATA_W-1:0] xa3_r, ya3_r, mn3_r;
  logic [DATA_W:0]   sum3_r;
  logic [PROD_W-1:0] xx3_r, yy3_r, p3_r;
  logic [EPS_W+FRAC_W-1:0] ep3_r;
  mode_t             m3_r;
  // stage 4
  logic              v4_r, xn4_r, yn4_r, xz4_r, yz4_r, xy4_r;
  logic [DATA_W-1:0] xa4_r, ya4_r, mn4_r;
  logic [DATA_W:0]   sum4_r;
  logic [PROD_W:0]   p2_4_r, npos4_r, nneg4_r;
  logic [PROD_W-1:0] q4_r, p4_r;
  logic [DEN_W-1:0]  dpos4_r;
  logic [PROD_W+1:0] pa4_r, pb4_r;
  mode_t             m4_r;
  // stage 5
  logic              v5_r, xn5_r, yn5_r, xz5_r, yz5_r, dz5_r, vn5_r;
  logic [DATA_W-1:0] xa5_r, ya5_r, mn5_r;
  logic [DATA_W:0]   sum5_r;
  logic [PROD_W:0]   p2_5_r, nmag5_r;
  logic [PROD_W-1:0] q5_r;
  logic [DEN_W-1:0]  d5_r;
  logic [NUM_W-1:0]  vnum5_r;
  mode_t             m5_r;
  // stage 6
  logic              v6_r;
  side_t             side6_r;
  logic [NUM_W-1:0]  num6_r [LANES];
  logic [DEN_W-1:0]  den6_r [LANES];

  logic              xneg_c, yneg_c;
  logic [DATA_W-1:0] xa_c, ya_c;
  logic              xyneg_c;
  logic [DATA_W:0]   xys_c;
  logic [DEN_W-1:0]  d_nxt;
  logic [NUM_W-1:0]  numa_nxt;
  logic [DEN_W-1:0]  dena_nxt;

  assign xneg_c  = x1_r[DATA_W-1];
  assign yneg_c  = y1_r[DATA_W-1];
  assign xa_c    = xneg_c ? (~x1_r + DATA_W'(1)) : x1_r;
  assign ya_c    = yneg_c ? (~y1_r + DATA_W'(1)) : y1_r;
  assign xyneg_c = (xn3_r != yn3_r) && (xa3_r != '0) && (ya3_r != '0);
  // plain X+Y for the van Albada numerator; the stored sum carries the extra LSB
  assign xys_c   = sum3_r - (DATA_W+1)'(1);
  assign d_nxt   = dpos4_r - DEN_W'(xy4_r ? p4_r : '0);

  always_comb begin
    numa_nxt = '0;
    dena_nxt = DEN_W'(1);
    unique case (m5_r)
      MODE_BLEND: begin
        numa_nxt = NUM_W'({p2_5_r, FRAC_W'(0)});
        dena_nxt = DEN_W'(q5_r);
      end
      MODE_ALBADA: begin
        numa_nxt = vnum5_r;
        dena_nxt = DEN_W'(q5_r);
      end
      MODE_BARTH: begin
        numa_nxt = NUM_W'({xa5_r, FRAC_W'(0)});
        dena_nxt = yz5_r ? DEN_W'(1) : DEN_W'(ya5_r);
      end
      MODE_VENKAT: begin
        numa_nxt = NUM_W'({nmag5_r, FRAC_W'(0)});
        dena_nxt = dz5_r ? DEN_W'(1) : d5_r;
      end
      default: begin
        numa_nxt = '0;
        dena_nxt = DEN_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= left_diff;
      y1_r <= right_diff;
      m1_r <= mode;
      e1_r <= eps;

      xn2_r  <= xneg_c;
      yn2_r  <= yneg_c;
      xa2_r  <= xa_c;
      ya2_r  <= ya_c;
      mn2_r  <= (xa_c < ya_c) ? xa_c : ya_c;
      sum2_r <= (DATA_W+1)'(xa_c) + (DATA_W+1)'(ya_c) + (DATA_W+1)'(1);
      m2_r   <= m1_r;
      e2_r   <= e1_r;

      xn3_r  <= xn2_r;
      yn3_r  <= yn2_r;
      xa3_r  <= xa2_r;
      ya3_r  <= ya2_r;
      mn3_r  <= mn2_r;
      sum3_r <= sum2_r;
      xx3_r  <= PROD_W'(xa2_r) * PROD_W'(xa2_r);
      yy3_r  <= PROD_W'(ya2_r) * PROD_W'(ya2_r);
      p3_r   <= PROD_W'(xa2_r) * PROD_W'(ya2_r);
      ep3_r  <= {e2_r, FRAC_W'(0)};
      m3_r   <= m2_r;

      xn4_r   <= xn3_r;
      yn4_r   <= yn3_r;
      xz4_r   <= (xa3_r == '0);
      yz4_r   <= (ya3_r == '0);
      xy4_r   <= xyneg_c;
      xa4_r   <= xa3_r;
      ya4_r   <= ya3_r;
      mn4_r   <= mn3_r;
      sum4_r  <= sum3_r;
      p4_r    <= p3_r;
      p2_4_r  <= {p3_r, 1'b0};
      q4_r    <= xx3_r + yy3_r + PROD_W'(1);
      npos4_r <= (PROD_W+1)'(xx3_r) + (PROD_W+1)'(ep3_r)
               + (xyneg_c ? '0 : {p3_r, 1'b0});
      nneg4_r <= xyneg_c ? {p3_r, 1'b0} : '0;
      dpos4_r <= DEN_W'(xx3_r) + DEN_W'({yy3_r, 1'b0}) + DEN_W'(ep3_r)
               + (xyneg_c ? '0 : DEN_W'(p3_r));
      // split the van Albada product into two partial products
      pa4_r   <= (PROD_W+2)'(p3_r[DATA_W-1:0]) * (PROD_W+2)'(xys_c);
      pb4_r   <= (PROD_W+2)'(p3_r[PROD_W-1:DATA_W]) * (PROD_W+2)'(xys_c);
      m4_r    <= m3_r;

      xn5_r   <= xn4_r;
      yn5_r   <= yn4_r;
      xz5_r   <= xz4_r;
      yz5_r   <= yz4_r;
      xa5_r   <= xa4_r;
      ya5_r   <= ya4_r;
      mn5_r   <= mn4_r;
      sum5_r  <= sum4_r;
      p2_5_r  <= p2_4_r;
      q5_r    <= q4_r;
      d5_r    <= d_nxt;
      dz5_r   <= (d_nxt == '0);
      vn5_r   <= (npos4_r < nneg4_r);
      nmag5_r <= (npos4_r < nneg4_r) ? (nneg4_r - npos4_r) : (npos4_r - nneg4_r);
      vnum5_r <= NUM_W'(pa4_r) + (NUM_W'(pb4_r) << DATA_W);
      m5_r    <= m4_r;

      side6_r.mode  <= m5_r;
      side6_r.xneg  <= xn5_r;
      side6_r.yneg  <= yn5_r;
      side6_r.xzero <= xz5_r;
      side6_r.yzero <= yz5_r;
      side6_r.dzero <= dz5_r;
      side6_r.vneg  <= vn5_r;
      side6_r.mn    <= mn5_r;
      num6_r[0]     <= numa_nxt;
      den6_r[0]     <= dena_nxt;
      num6_r[1]     <= NUM_W'(p2_5_r);
      den6_r[1]     <= DEN_W'(sum5_r);
    end
  end

  assign o_valid = v6_r;
  assign o_side  = side6_r;
  assign o_num   = num6_r;
  assign o_den   = den6_r;

endmodule

/* rtl/ssl_div.sv */
// ----------------------------------------------------------------------------
// ssl_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with an
// up-front overflow test against the quotient width.
// ----------------------------------------------------------------------------
module ssl_div import ssl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [NUM_W-1:0]  num [LANES],
  input  logic [DEN_W-1:0]  den [LANES],
  output logic              o_valid,
  output side_t             o_side,
  output logic [QUOT_W-1:0] o_quot [LANES],
  output logic              o_ovf [LANES]
);

  logic  v_r    [QUOT_W+1];
  side_t side_r [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUOT_W; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= QUOT_W; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      for (int k = 1; k <= QUOT_W; k++) side_r[k] <= side_r[k-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [REM_W-1:0]  rem_r [QUOT_W+1];
    logic [QUOT_W-1:0] low_r [QUOT_W+1];
    logic [QUOT_W-1:0] quo_r [QUOT_W+1];
    logic [DEN_W-1:0]  den_r [QUOT_W+1];
    logic              ovf_r [QUOT_W+1];
    logic [REM_W-1:0]  rem_nxt [QUOT_W];
    logic              ge_c    [QUOT_W];

    always_comb begin
      logic [REM_W-1:0] t;
      for (int k = 0; k < QUOT_W; k++) begin
        t          = {rem_r[k][REM_W-2:0], low_r[k][QUOT_W-1]};
        ge_c[k]    = (t >= REM_W'(den_r[k]));
        rem_nxt[k] = ge_c[k] ? (t - REM_W'(den_r[k])) : t;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ovf_r[0] <= ((DEN_W+QUOT_W)'(num[l]) >= {den[l], QUOT_W'(0)});
        rem_r[0] <= REM_W'(num[l][NUM_W-1:QUOT_W]);
        low_r[0] <= num[l][QUOT_W-1:0];
        quo_r[0] <= '0;
        den_r[0] <= den[l];
        for (int k = 1; k <= QUOT_W; k++) begin
          ovf_r[k] <= ovf_r[k-1];
          rem_r[k] <= rem_nxt[k-1];
          low_r[k] <= {low_r[k-1][QUOT_W-2:0], 1'b0};
          quo_r[k] <= {quo_r[k-1][QUOT_W-2:0], ge_c[k-1]};
          den_r[k] <= den_r[k-1];
        end
      end
    end

    assign o_quot[l] = quo_r[QUOT_W];
    assign o_ovf[l]  = ovf_r[QUOT_W];
  end

  assign o_valid = v_r[QUOT_W];
  assign o_side  = side_r[QUOT_W];

endmodule

/* rtl/ssl_back.sv */
// ----------------------------------------------------------------------------
// ssl_back
// Blend weighting, per-mode magnitude and sign selection, saturation and the
// output register.
// ----------------------------------------------------------------------------
module ssl_back import ssl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [QUOT_W-1:0] quot [LANES],
  input  logic              ovf [LANES],
  output logic              o_valid,
  output logic [DATA_W-1:0] o_value,
  output logic              o_sat
);

  localparam logic [MAG_W-1:0] ONE_M  = MAG_W'(1) << FRAC_W;
  localparam logic [MAG_W-1:0] HALF_M = MAG_W'(1) << (DATA_W - 1);
  localparam int T1_W  = FRAC_W + 1 + DATA_W;
  localparam int T2_W  = FRAC_W + 1 + QUOT_W;
  localparam int ACC_W = FRAC_W + QUOT_W + 2;

  logic              v1_r, v2_r, v3_r;
  side_t             s1_r;
  logic [QUOT_W-1:0] qa1_r, qb1_r;
  logic              oa1_r, ob1_r;
  logic [T1_W-1:0]   t1_r;
  logic [T2_W-1:0]   t2_r;
  logic [MAG_W-1:0]  mag2_r;
  logic              neg2_r, big2_r, frc2_r;
  logic [DATA_W-1:0] val3_r;
  logic              sat3_r;

  logic [FRAC_W:0]   z2_c;
  logic [ACC_W-1:0]  acc_c;
  logic [MAG_W-1:0]  blend_c, mag_nxt;
  logic              same_c, neg_nxt, big_nxt, frc_nxt;
  logic              clip_c;

  assign z2_c    = quot[0][FRAC_W:0];
  assign acc_c   = ACC_W'(t1_r) + ACC_W'(t2_r);
  assign blend_c = MAG_W'(acc_c >> FRAC_W);
  assign same_c  = (s1_r.xneg == s1_r.yneg);

  always_comb begin
    mag_nxt = '0;
    neg_nxt = 1'b0;
    big_nxt = 1'b0;
    frc_nxt = 1'b0;
    unique case (s1_r.mode)
      MODE_NONE:   mag_nxt = ONE_M;
      MODE_FIRST:  mag_nxt = '0;
      MODE_MINMOD: begin
        mag_nxt = same_c ? MAG_W'(s1_r.mn) : '0;
        neg_nxt = s1_r.xneg;
      end
      MODE_VANLEER: begin
        mag_nxt = same_c ? MAG_W'(qb1_r) : '0;
        big_nxt = same_c && ob1_r;
        neg_nxt = s1_r.xneg;
      end
      MODE_BLEND: begin
        mag_nxt = same_c ? blend_c : '0;
        big_nxt = same_c && (oa1_r || ob1_r);
        neg_nxt = s1_r.xneg;
      end
      MODE_ALBADA: begin
        mag_nxt = same_c ? MAG_W'(qa1_r) : '0;
        big_nxt = same_c && oa1_r;
        neg_nxt = s1_r.xneg;
      end
      MODE_BARTH: begin
        if (s1_r.yzero) begin
          frc_nxt = 1'b1;
          neg_nxt = s1_r.xneg;
          mag_nxt = s1_r.xneg ? HALF_M : ONE_M;
        end else begin
          neg_nxt = !same_c && !s1_r.xzero;
          // clamp positive ratios to one
          if (!neg_nxt && (oa1_r || (MAG_W'(qa1_r) > ONE_M))) begin
            mag_nxt = ONE_M;
          end else begin
            mag_nxt = MAG_W'(qa1_r);
            big_nxt = oa1_r;
          end
        end
      end
      MODE_VENKAT: begin
        if (s1_r.dzero) begin
          frc_nxt = 1'b1;
          big_nxt = 1'b1;
        end else begin
          neg_nxt = s1_r.vneg;
          mag_nxt = MAG_W'(qa1_r);
          big_nxt = oa1_r;
        end
      end
      default: mag_nxt = '0;
    endcase
  end

  assign clip_c = big2_r || (neg2_r ? (mag2_r > HALF_M) : (mag2_r > (HALF_M - MAG_W'(1))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= in_side;
      qa1_r <= quot[0];
      qb1_r <= quot[1];
      oa1_r <= ovf[0];
      ob1_r <= ovf[1];
      t1_r  <= T1_W'((FRAC_W+1)'(ONE_M) - z2_c) * T1_W'(in_side.mn);
      t2_r  <= T2_W'(z2_c) * T2_W'(quot[1]);

      mag2_r <= mag_nxt;
      neg2_r <= neg_nxt;
      big2_r <= big_nxt;
      frc2_r <= frc_nxt;

      sat3_r <= clip_c || frc2_r;
      if (clip_c) begin
        val3_r <= neg2_r ? HALF_M[DATA_W-1:0] : (HALF_M[DATA_W-1:0] - DATA_W'(1));
      end else begin
        val3_r <= neg2_r ? (~mag2_r[DATA_W-1:0] + DATA_W'(1)) : mag2_r[DATA_W-1:0];
      end
    end
  end

  assign o_valid = v3_r;
  assign o_value = val3_r;
  assign o_sat   = sat3_r;

endmodule

/* rtl/selectable_slope_limiter_core.sv */
// ----------------------------------------------------------------------------
// selectable_slope_limiter_core
// TVD slope limiter on signed Q16.16 differences with a selectable limiter.
// ----------------------------------------------------------------------------
// Takes one pair of differences per clock unless the output waits, and
// returns one limited value per pair, in order, through six operand stages
// (magnitudes, 32x32 products, sums), a 35-stage divider that yields one
// quotient bit per stage, and three stages for blend weighting, saturation
// and the output register. The whole pipeline holds when the output waits;
// the mode and epsilon registers should be written only while it is empty.
// ----------------------------------------------------------------------------
module selectable_slope_limiter_core import ssl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ssl_in_if.sink       in_ch,
  ssl_out_if.source    out_ch,
  ssl_cfg_if.sink      cfg_ch
);

  mode_t             mode_r;
  logic [EPS_W-1:0]  eps_r;
  logic              adv;
  logic              out_valid;

  logic              f_valid;
  side_t             f_side;
  logic [NUM_W-1:0]  f_num [LANES];
  logic [DEN_W-1:0]  f_den [LANES];

  logic              d_valid;
  side_t             d_side;
  logic [QUOT_W-1:0] d_quot [LANES];
  logic              d_ovf [LANES];

  // hold every stage while the result waits
  assign adv          = !out_valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MINMOD;
      eps_r  <= EPS_W'(1);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_MODE) mode_r <= mode_t'(cfg_ch.data[2:0]);
      if (cfg_ch.index == REG_EPS)  eps_r  <= cfg_ch.data[EPS_W-1:0];
    end
  end

  ssl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_ch.valid),
    .left_diff  (in_ch.left_diff),
    .right_diff (in_ch.right_diff),
    .mode       (mode_r),
    .eps        (eps_r),
    .o_valid    (f_valid),
    .o_side     (f_side),
    .o_num      (f_num),
    .o_den      (f_den)
  );

  ssl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (f_valid),
    .in_side  (f_side),
    .num      (f_num),
    .den      (f_den),
    .o_valid  (d_valid),
    .o_side   (d_side),
    .o_quot   (d_quot),
    .o_ovf    (d_ovf)
  );

  ssl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (d_valid),
    .in_side  (d_side),
    .quot     (d_quot),
    .ovf      (d_ovf),
    .o_valid  (out_valid),
    .o_value  (out_ch.limited_value),
    .o_sat    (out_ch.saturated)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the selectable slope limiter against a bit-exact predictor of every
// limiter mode, with random handshake gaps on the request and result sides.
// ----------------------------------------------------------------------------
module tb_top;
  import ssl_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              sat;
  } limit_t;

  localparam logic [127:0] ONE_Q   = 128'h1_0000;
  localparam logic [127:0] MAX_POS = 128'h7FFF_FFFF;
  localparam logic [127:0] MAX_NEG = 128'h8000_0000;
  localparam int           STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;

  ssl_in_if  in_ch ();
  ssl_out_if out_ch ();
  ssl_cfg_if cfg_ch ();

  selectable_slope_limiter_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mode_t        lim_mode = MODE_MINMOD;
  logic [30:0]  lim_eps  = 31'd1;
  limit_t       pending_limits[$];
  int           err_count = 0;
  bit           no_gaps   = 0;
  int           idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clip a magnitude with its sign to the signed 32-bit range.
  function automatic limit_t clip_signed(bit neg, logic [127:0] mag);
    limit_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > MAX_NEG) begin
        r.sat = 1'b1;
        r.value = MAX_NEG[31:0];
      end else begin
        r.value = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > MAX_POS) begin
        r.sat = 1'b1;
        r.value = MAX_POS[31:0];
      end else begin
        r.value = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic limit_t predict_limit(logic [31:0] x, logic [31:0] y);
    logic [127:0] ax, ay, mn, p, p2, q, z2, z3, acc, mag;
    logic [127:0] ep, x2, npos, nneg, dpos, dneg, den, nmag;
    bit xn, yn, same, neg;
    limit_t r;
    xn = x[31];
    yn = y[31];
    ax = {96'd0, xn ? (32'd0 - x) : x};
    ay = {96'd0, yn ? (32'd0 - y) : y};
    same = (xn == yn);
    mn = (ax < ay) ? ax : ay;
    p = ax * ay;
    p2 = p << 1;
    r.value = '0;
    r.sat = 1'b0;
    case (lim_mode)
      MODE_NONE: r = clip_signed(1'b0, ONE_Q);
      MODE_FIRST: r.value = '0;
      MODE_MINMOD: if (same) r = clip_signed(xn, mn);
      MODE_VANLEER: if (same) r = clip_signed(xn, p2 / (ax + ay + 1));
      MODE_BLEND: if (same) begin
        q = ax * ax + ay * ay + 1;
        z2 = {64'd0, 64'((p2 << FRAC_W) / q)};
        z3 = {64'd0, 64'(p2 / (ax + ay + 1))};
        acc = {64'd0, 64'(ONE_Q - z2)} * mn + z2 * z3;
        r = clip_signed(xn, acc / ONE_Q);
      end
      MODE_ALBADA: if (same) begin
        q = ax * ax + ay * ay + 1;
        r = clip_signed(xn, (p * (ax + ay)) / q);
      end
      MODE_BARTH: begin
        if (ay == 0) begin
          r.sat = 1'b1;
          r.value = xn ? MAX_NEG[31:0] : ONE_Q[31:0];
        end else begin
          neg = (xn != yn) && (ax != 0);
          mag = (ax << FRAC_W) / ay;
          if (!neg && mag > ONE_Q) mag = ONE_Q;
          r = clip_signed(neg, mag);
        end
      end
      default: begin
        ep = {97'd0, lim_eps} * ONE_Q;
        x2 = ax * ax;
        npos = x2 + ep;
        dpos = x2 + ((ay * ay) << 1) + ep;
        nneg = '0;
        dneg = '0;
        if ((xn != yn) && ax != 0 && ay != 0) begin
          nneg = p2;
          dneg = p;
        end else begin
          npos = npos + p2;
          dpos = dpos + p;
        end
        den = dpos - dneg;
        if (npos >= nneg) begin
          neg = 1'b0;
          nmag = npos - nneg;
        end else begin
          neg = 1'b1;
          nmag = nneg - npos;
        end
        if (den == 0) begin
          r.sat = 1'b1;
          r.value = MAX_POS[31:0];
        end else begin
          r = clip_signed(neg, (nmag << FRAC_W) / den);
        end
      end
    endcase
    return r;
  endfunction

  // Send one pair of differences; predict at the accepting edge.
  task automatic send_pair(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.left_diff <= x;
    in_ch.right_diff <= y;
    do @(posedge clk); while (!in_ch.ready);
    pending_limits.push_back(predict_limit(x, y));
  endtask

  // Lower the request line and let the pipeline empty.
  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_limits.size() == 0);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
    drain_pipe();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MODE) lim_mode = mode_t'(data[2:0]);
    else if (idx == REG_EPS) lim_eps = data[30:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_diff();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      4: return 32'($urandom_range(0, 64)) - 32'd32;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
    endcase
  endfunction

  task automatic test_extremes();
    write_reg(REG_MODE, 32'(MODE_NONE));
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    write_reg(REG_MODE, 32'(MODE_FIRST));
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // minmod of two most-negative values lands exactly on the negative limit
    write_reg(REG_MODE, 32'(MODE_MINMOD));
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    for (int m = MODE_VANLEER; m <= MODE_ALBADA; m++) begin
      write_reg(REG_MODE, 32'(m));
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h7FFF_FFFF, 32'h0000_0001);
    end
    // Barth with a zero divisor, both signs of x
    write_reg(REG_MODE, 32'(MODE_BARTH));
    send_pair(32'h0003_0000, 32'h0000_0000);
    send_pair(32'hFFFD_0000, 32'h0000_0000);
    send_pair(32'h8000_0000, 32'h0000_0001);
    // Venkatakrishnan zero denominator needs x = y = 0 and no epsilon
    write_reg(REG_MODE, 32'(MODE_VENKAT));
    write_reg(REG_EPS, 32'd0);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0002_0000, 32'hFFFF_0000);
    write_reg(REG_EPS, 32'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_random_phases();
    logic [31:0] eps;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: eps = 32'd0;
        1: eps = 32'd1;
        2: eps = 32'h7FFF_FFFF;
        default: eps = $urandom;
      endcase
      write_reg(REG_EPS, eps);
      write_reg(REG_MODE, ph < 8 ? 32'(ph) : 32'($urandom_range(0, 7)));
      no_gaps = (ph % 3 == 0);
      for (int k = 0; k < 100; k++) send_pair(rand_diff(), rand_diff());
    end
    no_gaps = 0;
  endtask

  // Result side: draw a stall per result, then hold ready until a result moves.
  initial begin
    int w;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    limit_t exp_l;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_limits.size() == 0) begin
        $error("result with nothing pending: %h", out_ch.limited_value);
        err_count++;
      end else begin
        exp_l = pending_limits.pop_front();
        if (out_ch.limited_value !== exp_l.value) begin
          $error("limited_value: expected %h, got %h", exp_l.value, out_ch.limited_value);
          err_count++;
        end
        if (out_ch.saturated !== exp_l.sat) begin
          $error("saturated: expected %b, got %b", exp_l.sat, out_ch.saturated);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.left_diff = '0;
    in_ch.right_diff = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // reset mode is minmod with epsilon one
    send_pair(32'h0002_0000, 32'h0001_0000);
    test_extremes();
    test_random_phases();
    drain_pipe();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
